// ===== rtl/ec_rho_discrete_log_macros.svh =====
// Assertion macros shared by the ec_rho_discrete_log RTL.
// They expect the including module to have i_clk and an active-low i_rst_n.
`ifndef EC_RHO_DISCRETE_LOG_MACROS_SVH
`define EC_RHO_DISCRETE_LOG_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ECR_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ec_rho_discrete_log: property violated");

// Next-cycle implication, checked outside reset.
`define ECR_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ec_rho_discrete_log: property violated");

`endif

// ===== rtl/ecrho_pkg.sv =====
// Shared types and constants for the elliptic-curve rho discrete log block.
// No dependencies; used by ecrho_alu and ec_rho_discrete_log.
`default_nettype none
package ecrho_pkg;

    localparam int FIELD_BITS = 16;
    localparam int COUNT_BITS = 24;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [15:0] SPLIT_LOW_RESET  = 16'd33;
    localparam logic [15:0] SPLIT_HIGH_RESET = 16'd68;
    localparam logic [23:0] STEP_LIMIT_RESET = 24'd65536;

    // Register indexes on the configuration port (word address).
    localparam logic [1:0] REG_SPLIT_LOW  = 2'd0;
    localparam logic [1:0] REG_SPLIT_HIGH = 2'd1;
    localparam logic [1:0] REG_STEP_LIMIT = 2'd2;

    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_NOINV = 2'd1;
    localparam logic [1:0] STATUS_LIMIT = 2'd2;

    typedef struct packed {
        logic [15:0] field_prime;
        logic [15:0] curve_a;
        logic [15:0] base_x;
        logic [15:0] base_y;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [15:0] group_order;
    } t_in;

    typedef struct packed {
        logic [15:0] log_value;
        logic [1:0]  status;
        logic [23:0] steps_used;
    } t_out;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_INV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic ok;
    } t_alu_rsp;

endpackage
`default_nettype wire

// ===== rtl/ecrho_alu.sv =====
// Shared modular arithmetic unit: bit-serial multiply mod n and extended
// Euclid inverse mod n built on a bit-serial divider. Uses ecrho_pkg.
`default_nettype none
`include "ec_rho_discrete_log_macros.svh"
module ecrho_alu #(
    parameter int W = ecrho_pkg::FIELD_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  ecrho_pkg::t_alu_req   i_req,
    input  wire  [W-1:0]          i_a,
    input  wire  [W-1:0]          i_b,
    input  wire  [W-1:0]          i_n,
    output ecrho_pkg::t_alu_rsp   o_rsp,
    output logic [W-1:0]          o_res
);
    localparam int BW = $clog2(W);

    typedef enum logic [6:0] {
        A_IDLE = 7'b0000001,
        A_MUL  = 7'b0000010,
        A_LOOP = 7'b0000100,
        A_DIV  = 7'b0001000,
        A_DQ   = 7'b0010000,
        A_TUPD = 7'b0100000,
        A_DONE = 7'b1000000
    } t_ast;

    t_ast          r_st;
    logic [BW-1:0] r_bit;
    logic [W:0]    r_acc;
    logic [W-1:0]  r_sh, r_b, r_n, r_r0, r_r1, r_t0, r_t1, r_res;
    logic          r_inv, r_ok;

    logic [W:0] mul_t, div_t, tupd_t;
    logic       div_q;

    // One multiply step: acc = 2*acc + bit*b, reduced mod n.
    always_comb begin
        mul_t = {r_acc[W-1:0], 1'b0};
        if (mul_t >= {1'b0, r_n}) mul_t = mul_t - {1'b0, r_n};
        if (r_sh[W-1]) mul_t = mul_t + {1'b0, r_b};
        if (mul_t >= {1'b0, r_n}) mul_t = mul_t - {1'b0, r_n};
    end

    // One restoring-division step; the quotient bit shifts into r_sh.
    always_comb begin
        div_t = {r_acc[W-1:0], r_sh[W-1]};
        div_q = 1'b0;
        if (div_t >= {1'b0, r_b}) begin
            div_t = div_t - {1'b0, r_b};
            div_q = 1'b1;
        end
    end

    // Euclid coefficient update: t1' = (t0 - q*t1) mod n, product in r_acc.
    always_comb begin
        if (r_t0 >= r_acc[W-1:0]) tupd_t = {1'b0, r_t0} - r_acc;
        else tupd_t = {1'b0, r_t0} + {1'b0, r_n} - r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            unique case (r_st)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_n <= i_n;
                        if (i_req.op == ecrho_pkg::OP_MUL) begin
                            r_acc <= '0;
                            r_sh  <= i_a;
                            r_b   <= i_b;
                            r_bit <= BW'(W - 1);
                            r_inv <= 1'b0;
                            r_st  <= A_MUL;
                        end else begin
                            r_r0  <= i_n;
                            r_r1  <= i_a;
                            r_t0  <= '0;
                            r_t1  <= W'(1);
                            r_inv <= 1'b1;
                            r_st  <= A_LOOP;
                        end
                    end
                end
                A_MUL: begin
                    r_acc <= mul_t;
                    r_sh  <= {r_sh[W-2:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        if (r_inv) begin
                            r_st <= A_TUPD;
                        end else begin
                            r_res <= mul_t[W-1:0];
                            r_ok  <= 1'b1;
                            r_st  <= A_DONE;
                        end
                    end
                end
                A_LOOP: begin
                    if (r_r1 == '0) begin
                        r_ok  <= (r_r0 == W'(1));
                        r_res <= r_t0;
                        r_st  <= A_DONE;
                    end else begin
                        r_acc <= '0;
                        r_sh  <= r_r0;
                        r_b   <= r_r1;
                        r_bit <= BW'(W - 1);
                        r_st  <= A_DIV;
                    end
                end
                A_DIV: begin
                    r_acc <= div_t;
                    r_sh  <= {r_sh[W-2:0], div_q};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) r_st <= A_DQ;
                end
                A_DQ: begin
                    // Quotient stays in r_sh as the multiplier of q*t1.
                    r_r0  <= r_r1;
                    r_r1  <= r_acc[W-1:0];
                    r_acc <= '0;
                    r_b   <= r_t1;
                    r_bit <= BW'(W - 1);
                    r_st  <= A_MUL;
                end
                A_TUPD: begin
                    r_t0 <= r_t1;
                    r_t1 <= tupd_t[W-1:0];
                    r_st <= A_LOOP;
                end
                A_DONE: begin
                    r_st <= A_IDLE;
                end
                default: r_st <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done = (r_st == A_DONE);
    assign o_rsp.ok   = r_ok;
    assign o_res      = r_res;

    `ECR_IMPLY(a_mul_acc_reduced, r_st == A_MUL, r_acc < {1'b0, r_n})
    `ECR_IMPLY(a_div_rem_below, r_st == A_DIV, r_acc < {1'b0, r_b} && r_b != '0)
    `ECR_NEXT(a_done_single, r_st == A_DONE, r_st == A_IDLE)

endmodule
`default_nettype wire

// ===== rtl/ec_rho_discrete_log.sv =====
// Top level of the elliptic-curve rho discrete log block: configuration
// port, job sequencer and point arithmetic. Uses ecrho_pkg and ecrho_alu.
//
// Usage: one job per input transfer on i_in_valid/o_in_ready carries q, A,
// G, R and the order m. The block walks a Pollard rho sequence with a
// tortoise and a hare and delivers one result per job on o_out_valid /
// i_out_ready: the logarithm, a status code and the hare step count.
// o_in_ready is high only while the sequencer is idle; one job at a time.
// Arithmetic: one shared unit does all modular products and inversions. A
// walk step is one inversion and three (addition) or four (doubling)
// multiplies plus some adds; a round is three walk steps, and a job is
// bounded by the step limit. A job with q < 3 or m < 2 skips the walk and
// goes straight to the final state.
// Loading the points costs up to five multiplies before the walk.
// When the receiver stalls, the finished result waits in the output register
// and the sequencer holds in its final state until that register frees up.
// Reset (synchronous, active low) returns to idle with the registers at
// their default values; configuration is written through the APB port.
`default_nettype none
`include "ec_rho_discrete_log_macros.svh"
module ec_rho_discrete_log #(
    parameter int FIELD_BITS = ecrho_pkg::FIELD_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  ecrho_pkg::t_in     i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output ecrho_pkg::t_out    o_out_data,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int W = FIELD_BITS;
    localparam int CW = ecrho_pkg::COUNT_BITS + 1;

    typedef enum logic [26:0] {
        S_IDLE   = 27'd1 << 0,
        S_LD_A   = 27'd1 << 1,
        S_LD_GX  = 27'd1 << 2,
        S_LD_GY  = 27'd1 << 3,
        S_LD_GYS = 27'd1 << 4,
        S_LD_RX  = 27'd1 << 5,
        S_LD_RY  = 27'd1 << 6,
        S_LD_RYS = 27'd1 << 7,
        S_WINIT  = 27'd1 << 8,
        S_WSEL   = 27'd1 << 9,
        S_PADD   = 27'd1 << 10,
        S_DBL1   = 27'd1 << 11,
        S_DBL2   = 27'd1 << 12,
        S_DBL3   = 27'd1 << 13,
        S_DBL4   = 27'd1 << 14,
        S_SLOPE  = 27'd1 << 15,
        S_KSQ    = 27'd1 << 16,
        S_X3A    = 27'd1 << 17,
        S_X3B    = 27'd1 << 18,
        S_Y3B    = 27'd1 << 19,
        S_WDONE  = 27'd1 << 20,
        S_ROUND  = 27'd1 << 21,
        S_COL1   = 27'd1 << 22,
        S_COL2   = 27'd1 << 23,
        S_START  = 27'd1 << 24,
        S_WAIT   = 27'd1 << 25,
        S_FIN    = 27'd1 << 26
    } t_state;

    function automatic logic [W-1:0] f_add(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] n);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, n}) s = s - {1'b0, n};
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] n);
        logic [W:0] s;
        if (a >= b) s = {1'b0, a} - {1'b0, b};
        else s = {1'b0, a} + {1'b0, n} - {1'b0, b};
        return s[W-1:0];
    endfunction

    t_state r_state, r_ret;
    logic [15:0] r_split_low, r_split_high;
    logic [23:0] r_limit;

    logic [W-1:0] r_q, r_m, r_a, r_gx, r_gy, r_rx, r_ry;
    logic [W-1:0] r_hx, r_hy, r_hcr, r_hcg, r_tx, r_ty, r_tcr, r_tcg;
    logic [W-1:0] r_px, r_py, r_qx, r_qy, r_cr, r_cg;
    logic [W-1:0] r_u, r_v, r_t, r_k, r_iv, r_res;
    logic         r_ok;
    logic [1:0]   r_phase;
    logic [CW-1:0] r_cnt;
    logic [15:0]  r_log;
    logic [1:0]   r_status;
    logic         r_ov;
    ecrho_pkg::t_out r_out;

    ecrho_pkg::t_alu_op r_aop;
    logic [W-1:0] r_opa, r_opb, r_opn;
    ecrho_pkg::t_alu_req alu_req;
    ecrho_pkg::t_alu_rsp alu_rsp;
    logic [W-1:0] alu_res;

    logic          cfg_wr;
    logic          fin_load;
    logic [W-1:0]  w_x, w_y, w_cr, w_cg, x3;
    logic [CW-1:0] cnt_nx;

    assign alu_req.start = (r_state == S_START);
    assign alu_req.op    = r_aop;

    ecrho_alu #(.W(W)) u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .i_a    (r_opa),
        .i_b    (r_opb),
        .i_n    (r_opn),
        .o_rsp  (alu_rsp),
        .o_res  (alu_res)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            ecrho_pkg::REG_SPLIT_LOW:  prdata = {16'd0, r_split_low};
            ecrho_pkg::REG_SPLIT_HIGH: prdata = {16'd0, r_split_high};
            ecrho_pkg::REG_STEP_LIMIT: prdata = {8'd0, r_limit};
            default:                   prdata = '0;
        endcase
    end

    // The tortoise walks in phase 2, the hare in phases 0 and 1.
    assign w_x    = (r_phase == 2'd2) ? r_tx  : r_hx;
    assign w_y    = (r_phase == 2'd2) ? r_ty  : r_hy;
    assign w_cr   = (r_phase == 2'd2) ? r_tcr : r_hcr;
    assign w_cg   = (r_phase == 2'd2) ? r_tcg : r_hcg;
    assign x3     = f_sub(r_u, r_qx, r_q);
    assign cnt_nx = r_cnt + CW'(2);

    // The finished result moves into the output register once it is free.
    assign fin_load = (r_state == S_FIN) && (!r_ov || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ov         <= 1'b0;
            r_split_low  <= ecrho_pkg::SPLIT_LOW_RESET;
            r_split_high <= ecrho_pkg::SPLIT_HIGH_RESET;
            r_limit      <= ecrho_pkg::STEP_LIMIT_RESET;
            r_hx         <= '1;
            r_tx         <= '1;
            r_hy         <= '0;
            r_ty         <= '0;
            r_hcr        <= '0;
            r_hcg        <= '0;
            r_tcr        <= '0;
            r_tcg        <= '0;
            r_cnt        <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    ecrho_pkg::REG_SPLIT_LOW:  r_split_low  <= pwdata[15:0];
                    ecrho_pkg::REG_SPLIT_HIGH: r_split_high <= pwdata[15:0];
                    ecrho_pkg::REG_STEP_LIMIT: r_limit      <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (fin_load) r_ov <= 1'b1;
            else if (r_ov && i_out_ready) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_q   <= W'(i_in_data.field_prime);
                        r_m   <= W'(i_in_data.group_order);
                        r_a   <= W'(i_in_data.curve_a);
                        r_gx  <= W'(i_in_data.base_x);
                        r_gy  <= W'(i_in_data.base_y);
                        r_rx  <= W'(i_in_data.target_x);
                        r_ry  <= W'(i_in_data.target_y);
                        r_cnt <= '0;
                        if (i_in_data.field_prime < 16'd3 || i_in_data.group_order < 16'd2) begin
                            r_log    <= '0;
                            r_status <= ecrho_pkg::STATUS_LIMIT;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_LD_A;
                        end
                    end
                end
                // Input coordinates and A are reduced mod q by a multiply by one.
                S_LD_A: begin
                    r_opa <= r_a; r_opb <= W'(1); r_opn <= r_q;
                    r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_LD_GX; r_state <= S_START;
                end
                S_LD_GX: begin
                    r_a <= r_res;
                    if (r_gx == r_q) begin
                        r_gy    <= '0;
                        r_state <= S_LD_RX;
                    end else begin
                        r_opa <= r_gx; r_opb <= W'(1); r_opn <= r_q;
                        r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_LD_GY; r_state <= S_START;
                    end
                end
                S_LD_GY: begin
                    r_gx  <= r_res;
                    r_opa <= r_gy; r_opb <= W'(1); r_opn <= r_q;
                    r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_LD_GYS; r_state <= S_START;
                end
                S_LD_GYS: begin
                    r_gy    <= r_res;
                    r_state <= S_LD_RX;
                end
                S_LD_RX: begin
                    if (r_rx == r_q) begin
                        r_ry    <= '0;
                        r_state <= S_WINIT;
                    end else begin
                        r_opa <= r_rx; r_opb <= W'(1); r_opn <= r_q;
                        r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_LD_RY; r_state <= S_START;
                    end
                end
                S_LD_RY: begin
                    r_rx  <= r_res;
                    r_opa <= r_ry; r_opb <= W'(1); r_opn <= r_q;
                    r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_LD_RYS; r_state <= S_START;
                end
                S_LD_RYS: begin
                    r_ry    <= r_res;
                    r_state <= S_WINIT;
                end
                S_WINIT: begin
                    r_hx <= r_q; r_hy <= '0; r_hcr <= '0; r_hcg <= '0;
                    r_tx <= r_q; r_ty <= '0; r_tcr <= '0; r_tcg <= '0;
                    r_phase <= 2'd0;
                    r_state <= S_WSEL;
                end
                S_WSEL: begin
                    r_px <= w_x;
                    r_py <= w_y;
                    if (w_x == r_q || 33'(w_x) <= 33'(r_split_low)) begin
                        r_qx <= r_rx;
                        r_qy <= r_ry;
                        r_cr <= f_add(w_cr, W'(1), r_m);
                        r_cg <= w_cg;
                    end else if (33'(w_x) < 33'(r_split_high)) begin
                        r_qx <= w_x;
                        r_qy <= w_y;
                        r_cr <= f_add(w_cr, w_cr, r_m);
                        r_cg <= f_add(w_cg, w_cg, r_m);
                    end else begin
                        r_qx <= r_gx;
                        r_qy <= r_gy;
                        r_cr <= w_cr;
                        r_cg <= f_add(w_cg, W'(1), r_m);
                    end
                    r_state <= S_PADD;
                end
                S_PADD: begin
                    if (r_px == r_q) begin
                        r_px    <= r_qx;
                        r_py    <= r_qy;
                        r_state <= S_WDONE;
                    end else if (r_qx == r_q) begin
                        r_state <= S_WDONE;
                    end else if (r_px == r_qx && r_py == r_qy) begin
                        r_opa <= f_add(r_py, r_py, r_q); r_opn <= r_q;
                        r_aop <= ecrho_pkg::OP_INV; r_ret <= S_DBL1; r_state <= S_START;
                    end else begin
                        r_v   <= f_sub(r_qy, r_py, r_q);
                        r_opa <= f_sub(r_qx, r_px, r_q); r_opn <= r_q;
                        r_aop <= ecrho_pkg::OP_INV; r_ret <= S_SLOPE; r_state <= S_START;
                    end
                end
                S_DBL1: begin
                    if (!r_ok) begin
                        r_px <= r_q; r_py <= '0; r_state <= S_WDONE;
                    end else begin
                        r_iv  <= r_res;
                        r_opa <= r_px; r_opb <= r_px; r_opn <= r_q;
                        r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_DBL2; r_state <= S_START;
                    end
                end
                S_DBL2: begin
                    r_t     <= r_res;
                    r_u     <= f_add(r_res, r_res, r_q);
                    r_state <= S_DBL3;
                end
                S_DBL3: begin
                    r_u     <= f_add(r_u, r_t, r_q);
                    r_state <= S_DBL4;
                end
                S_DBL4: begin
                    r_opa <= f_add(r_u, r_a, r_q); r_opb <= r_iv; r_opn <= r_q;
                    r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_KSQ; r_state <= S_START;
                end
                S_SLOPE: begin
                    if (!r_ok) begin
                        r_px <= r_q; r_py <= '0; r_state <= S_WDONE;
                    end else begin
                        r_opa <= r_v; r_opb <= r_res; r_opn <= r_q;
                        r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_KSQ; r_state <= S_START;
                    end
                end
                S_KSQ: begin
                    r_k   <= r_res;
                    r_opa <= r_res; r_opb <= r_res; r_opn <= r_q;
                    r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_X3A; r_state <= S_START;
                end
                S_X3A: begin
                    r_u     <= f_sub(r_res, r_px, r_q);
                    r_state <= S_X3B;
                end
                S_X3B: begin
                    r_u   <= x3;
                    r_opa <= r_k; r_opb <= f_sub(r_px, x3, r_q); r_opn <= r_q;
                    r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_Y3B; r_state <= S_START;
                end
                S_Y3B: begin
                    r_px    <= r_u;
                    r_py    <= f_sub(r_res, r_py, r_q);
                    r_state <= S_WDONE;
                end
                S_WDONE: begin
                    if (r_phase == 2'd2) begin
                        r_tx <= r_px; r_ty <= r_py; r_tcr <= r_cr; r_tcg <= r_cg;
                        r_state <= S_ROUND;
                    end else begin
                        r_hx <= r_px; r_hy <= r_py; r_hcr <= r_cr; r_hcg <= r_cg;
                        r_phase <= r_phase + 2'd1;
                        r_state <= S_WSEL;
                    end
                end
                S_ROUND: begin
                    r_cnt <= cnt_nx;
                    if (r_hx == r_tx && r_hy == r_ty) begin
                        r_v   <= f_sub(r_tcg, r_hcg, r_m);
                        r_opa <= f_sub(r_hcr, r_tcr, r_m); r_opn <= r_m;
                        r_aop <= ecrho_pkg::OP_INV; r_ret <= S_COL1; r_state <= S_START;
                    end else if (cnt_nx >= CW'(r_limit)) begin
                        r_log    <= '0;
                        r_status <= ecrho_pkg::STATUS_LIMIT;
                        r_state  <= S_FIN;
                    end else begin
                        r_phase <= 2'd0;
                        r_state <= S_WSEL;
                    end
                end
                S_COL1: begin
                    if (!r_ok) begin
                        r_log    <= '0;
                        r_status <= ecrho_pkg::STATUS_NOINV;
                        r_state  <= S_FIN;
                    end else begin
                        r_opa <= r_v; r_opb <= r_res; r_opn <= r_m;
                        r_aop <= ecrho_pkg::OP_MUL; r_ret <= S_COL2; r_state <= S_START;
                    end
                end
                S_COL2: begin
                    r_log    <= 16'(r_res);
                    r_status <= ecrho_pkg::STATUS_FOUND;
                    r_state  <= S_FIN;
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        r_res   <= alu_res;
                        r_ok    <= alu_rsp.ok;
                        r_state <= r_ret;
                    end
                end
                S_FIN: begin
                    if (fin_load) begin
                        r_out.log_value <= r_log;
                        r_out.status    <= r_status;
                        r_out.steps_used <= (r_cnt > CW'(ecrho_pkg::COUNT_MAX)) ?
                                            ecrho_pkg::COUNT_MAX : r_cnt[CW-2:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `ECR_IMPLY(a_walkers_reduced, r_state == S_WSEL, r_hx <= r_q && r_tx <= r_q)
    `ECR_IMPLY(a_coefs_below_m, r_state == S_ROUND, r_hcr < r_m && r_tcr < r_m)
    `ECR_NEXT(a_fin_delivers, fin_load, o_out_valid)

endmodule
`default_nettype wire
